// ===== src/sbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfp_pkg
// shared constants and types for the header byte frame parser
// ----------------------------------------------------------------------------
package sbfp_pkg;

    localparam logic [7:0] HEADER_VALUE = 8'h55;
    localparam int         FRAME_LEN    = 11;
    localparam int         PAIR_CNT     = 5;
    localparam int         CNT_W        = 4;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;

    typedef logic [7:0]       byte_t;
    typedef logic [15:0]      word_t;
    typedef logic [CNT_W-1:0] cnt_t;

endpackage

// ===== src/sbfp_channels.sv =====
// ----------------------------------------------------------------------------
// sbfp channels
// valid/ready channels for received bytes and decoded frames
// ----------------------------------------------------------------------------
interface sbfp_byte_if;
    import sbfp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfp_frame_if;
    import sbfp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t frame_type;
    word_t word_zero;
    word_t word_one;
    word_t word_two;
    word_t word_three;

    modport source (output valid, output frame_type, output word_zero, output word_one,
                    output word_two, output word_three, input ready);
    modport sink   (input valid, input frame_type, input word_zero, input word_one,
                    input word_two, input word_three, output ready);
endinterface

// ===== src/sync_byte_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sync_byte_frame_parser
// finds 0x55-headed 11-byte frames with an additive checksum in a byte stream
// ----------------------------------------------------------------------------
// usage
//   rx     : one received serial byte per beat (valid/ready)
//   frame  : one beat per good frame: frame type and four little-endian words
//   a byte goes into an input register on the beat; once the output register
//   is free, the window logic appends it, checks the header and, with 11 bytes
//   held, checks that the 8-bit sum of the first 10 bytes equals the 11th
//   the result of the closing byte passes the input register and then the
//   output register before frame.valid rises
//   throughput: one byte per cycle unless the output stalls; the window
//   update is one pass of append/shift muxes and a 10-input 8-bit adder tree
//   stall: the output register holds a result until taken; the input register
//   still takes one more byte meanwhile, then rx.ready drops until the output
//   frees up
//   reset: fill count cleared, input and output registers empty; window bytes
//   are not cleared since only entries below the fill count are ever read
// ----------------------------------------------------------------------------
module sync_byte_frame_parser (
    input  logic                clk,
    input  logic                rst_n,
    sbfp_byte_if.sink           rx,
    sbfp_frame_if.source        frame
);
    import sbfp_pkg::*;

    // input register
    logic  byte_vld_reg;
    byte_t byte_reg;

    // window state
    byte_t window_reg [FRAME_LEN];
    byte_t window_next [FRAME_LEN];
    cnt_t  fill_count_reg;
    cnt_t  fill_count_next;

    // output register
    logic  frame_vld_reg;
    byte_t frame_type_reg;
    word_t word_zero_reg;
    word_t word_one_reg;
    word_t word_two_reg;
    word_t word_three_reg;

    logic  out_free;
    logic  step;
    logic  emit;
    cnt_t  fill_eff;
    byte_t front;
    logic  hdr_bad;
    logic  full;
    byte_t appended [FRAME_LEN];
    byte_t pair_sum [PAIR_CNT];
    byte_t sum;

    // the window stage runs while a byte is held and the output is free
    assign out_free = !frame_vld_reg || frame.ready;
    assign step     = byte_vld_reg && out_free;
    assign rx.ready = !byte_vld_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            byte_vld_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    // window step
    always_comb
    begin
        // guard: an out-of-range count behaves as an empty window
        fill_eff = (fill_count_reg > CNT_FULL) ? CNT_ZERO : fill_count_reg;

        for (int i = 0; i < FRAME_LEN; i++)
        begin
            appended[i] = (cnt_t'(i) == fill_eff) ? byte_reg : window_reg[i];
        end

        front   = appended[0];
        hdr_bad = (front != HEADER_VALUE);
        full    = (fill_eff == CNT_FULL);

        // balanced adder tree over the first ten bytes
        for (int k = 0; k < PAIR_CNT; k++)
        begin
            pair_sum[k] = window_reg[2*k] + window_reg[2*k+1];
        end
        sum = (pair_sum[0] + pair_sum[1]) + (pair_sum[2] + pair_sum[3]) + pair_sum[4];

        emit            = 1'b0;
        fill_count_next = fill_count_reg;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            window_next[i] = window_reg[i];
        end

        if (step)
        begin
            priority if (hdr_bad || (full && sum != byte_reg))
            begin
                // drop the front byte: append then shift down by one
                for (int i = 0; i < FRAME_LEN - 1; i++)
                begin
                    window_next[i] = appended[i+1];
                end
                window_next[FRAME_LEN-1] = appended[FRAME_LEN-1];
                fill_count_next = fill_eff;
            end
            else if (!full)
            begin
                for (int i = 0; i < FRAME_LEN; i++)
                begin
                    window_next[i] = appended[i];
                end
                fill_count_next = fill_eff + cnt_t'(1);
            end
            else
            begin
                emit            = 1'b1;
                fill_count_next = CNT_ZERO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= CNT_ZERO;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            window_reg[i] <= window_next[i];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_vld_reg <= 1'b0;
        end
        else
        begin
            frame_vld_reg <= emit || (frame_vld_reg && !frame.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            frame_type_reg <= window_reg[1];
            word_zero_reg  <= {window_reg[3], window_reg[2]};
            word_one_reg   <= {window_reg[5], window_reg[4]};
            word_two_reg   <= {window_reg[7], window_reg[6]};
            word_three_reg <= {window_reg[9], window_reg[8]};
        end
    end

    assign frame.valid      = frame_vld_reg;
    assign frame.frame_type = frame_type_reg;
    assign frame.word_zero  = word_zero_reg;
    assign frame.word_one   = word_one_reg;
    assign frame.word_two   = word_two_reg;
    assign frame.word_three = word_three_reg;

`ifndef SYNTHESIS
    // fill count never leaves 0..10
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_FULL)
        else $error("fill count out of range");

    // a good frame empties the window and lands in the output register
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (fill_count_reg == CNT_ZERO) && frame_vld_reg)
        else $error("frame emit did not clear window");

    // the window count moves only when a byte is processed
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(fill_count_reg))
        else $error("fill count changed without a byte");

    // a frame is only produced from a full window with the header in front
    a_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (fill_eff == CNT_FULL) && (window_reg[0] == HEADER_VALUE))
        else $error("frame emitted from a partial window");
`endif

endmodule
